[src/ecadd_pkg.sv]
// ----------------------------------------------------------------------------
// ecadd_pkg: shared definitions for the affine point adder
// Widths, datapath opcodes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ecadd_pkg;

  localparam int unsigned ModBits = 32;
  localparam int unsigned CntBits = $clog2(ModBits + 1);

  typedef logic [ModBits-1:0] word_t;

  typedef enum logic [3:0] {
    OP_LOAD   = 4'd0,
    OP_REDUCE = 4'd1,
    OP_MUL    = 4'd2,
    OP_ADD    = 4'd3,
    OP_SUB    = 4'd4,
    OP_GCD    = 4'd5,
    OP_NOP    = 4'd6
  } dp_op_e;

  typedef enum logic [3:0] {
    R_AX  = 4'd0,
    R_AY  = 4'd1,
    R_BX  = 4'd2,
    R_BY  = 4'd3,
    R_CF  = 4'd4,
    R_T0  = 4'd5,
    R_T1  = 4'd6,
    R_T2  = 4'd7,
    R_LAM = 4'd8,
    R_THR = 4'd9,
    R_ZER = 4'd10
  } reg_sel_e;

  localparam logic [1:0] KindInf = 2'd0;
  localparam logic [1:0] KindA   = 2'd1;
  localparam logic [1:0] KindB   = 2'd2;
  localparam logic [1:0] KindSum = 2'd3;

  typedef struct packed {
    logic     go;
    dp_op_e   op;
    reg_sel_e src_a;
    reg_sel_e src_b;
    reg_sel_e dst;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic ax_eq_bx;
    logic ay_eq_by;
    logic ysum_zero;
    logic gcd_fail;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/ecadd_datapath.sv]
// ----------------------------------------------------------------------------
// ecadd_datapath: modular arithmetic unit
// Register file, bit-serial modular multiplier and reducer, and an extended
// gcd unit with one binary division step a cycle, paused while each quotient is multiplied.
// ----------------------------------------------------------------------------
`default_nettype none

module ecadd_datapath
  import ecadd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire word_t    n_i,
  input  wire word_t    coef_i,
  input  wire word_t    a_x_i,
  input  wire word_t    a_y_i,
  input  wire word_t    b_x_i,
  input  wire word_t    b_y_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_stat_t      stat_o,
  output word_t         ax_o,
  output word_t         ay_o,
  output word_t         bx_o,
  output word_t         by_o,
  output word_t         t0_o,
  output word_t         t1_o,
  output word_t         gcd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_RED  = 5'b00100,
    S_GDIV = 5'b01000,
    S_GTMU = 5'b10000
  } dp_state_e;

  dp_state_e   state_q, state_d;
  word_t       rf_q [11];
  word_t       n_q;
  word_t       opa_q, opb_q, acc_q;
  logic [ModBits:0] rem_q;
  logic [CntBits-1:0] cnt_q;
  reg_sel_e    dst_q;
  logic        done_q;
  // gcd state
  word_t       r0_q, r1_q, t0g_q, t1g_q, q_q, qrem_q;
  logic [CntBits-1:0] sh_q;

  word_t       srca, srcb;
  assign srca = rf_q[cmd_i.src_a];
  assign srcb = rf_q[cmd_i.src_b];

  function automatic word_t addm(word_t a, word_t b, word_t n);
    logic [ModBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[ModBits-1:0];
  endfunction

  function automatic word_t subm(word_t a, word_t b, word_t n);
    return (a >= b) ? a - b : a + (n - b);
  endfunction

  word_t dbl, stepv;
  assign dbl   = addm(acc_q, acc_q, n_q);
  assign stepv = opb_q[ModBits-1] ? addm(dbl, opa_q, n_q) : dbl;

  logic [ModBits:0] rem_sh;
  assign rem_sh = {rem_q[ModBits-1:0], opa_q[ModBits-1]};

  word_t q_shift_sub;
  logic  q_bit;
  word_t q_fin;
  logic [2*ModBits-1:0] dv_wide;
  assign dv_wide = {{ModBits{1'b0}}, r1_q} << sh_q;
  assign q_bit   = ({{ModBits{1'b0}}, qrem_q} >= dv_wide);
  assign q_shift_sub = qrem_q - dv_wide[ModBits-1:0];
  assign q_fin   = q_q | (q_bit ? ModBits'(1) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_i.go && (cmd_i.op == OP_LOAD || cmd_i.op == OP_ADD ||
              cmd_i.op == OP_SUB || cmd_i.op == OP_NOP)) begin
            done_q <= 1'b1;
          end
        end
        S_MUL:  if (cnt_q == CntBits'(1)) done_q <= 1'b1;
        S_RED:  if (cnt_q == CntBits'(1)) done_q <= 1'b1;
        S_GDIV: if (r1_q == '0) done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          case (cmd_i.op)
            OP_MUL:    state_d = S_MUL;
            OP_REDUCE: state_d = S_RED;
            OP_GCD:    state_d = S_GDIV;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_MUL:  if (cnt_q == CntBits'(1)) state_d = S_IDLE;
      S_RED:  if (cnt_q == CntBits'(1)) state_d = S_IDLE;
      S_GDIV: begin
        if (r1_q == '0) state_d = S_IDLE;
        else if (sh_q == '0) state_d = S_GTMU;
      end
      S_GTMU: if (cnt_q == CntBits'(1)) state_d = S_GDIV;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rf_q[R_THR] <= ModBits'(3);
    rf_q[R_ZER] <= '0;
    case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          dst_q <= cmd_i.dst;
          n_q   <= n_i;
          case (cmd_i.op)
            OP_LOAD: begin
              rf_q[R_AX] <= a_x_i;
              rf_q[R_AY] <= a_y_i;
              rf_q[R_BX] <= b_x_i;
              rf_q[R_BY] <= b_y_i;
              rf_q[R_CF] <= coef_i;
            end
            OP_ADD: rf_q[cmd_i.dst] <= addm(srca, srcb, n_i);
            OP_SUB: rf_q[cmd_i.dst] <= subm(srca, srcb, n_i);
            OP_MUL: begin
              opa_q <= srca;
              opb_q <= srcb;
              acc_q <= '0;
              cnt_q <= CntBits'(ModBits);
            end
            OP_REDUCE: begin
              opa_q <= srca;
              rem_q <= '0;
              cnt_q <= CntBits'(ModBits);
            end
            OP_GCD: begin
              r0_q   <= n_i;
              r1_q   <= srca;
              t0g_q  <= '0;
              t1g_q  <= ModBits'(1);
              qrem_q <= n_i;
              q_q    <= '0;
              sh_q   <= CntBits'(ModBits - 1);
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        acc_q <= stepv;
        opb_q <= opb_q << 1;
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) rf_q[dst_q] <= stepv;
      end
      S_RED: begin
        opa_q <= opa_q << 1;
        cnt_q <= cnt_q - CntBits'(1);
        if (rem_sh >= {1'b0, n_q}) rem_q <= rem_sh - {1'b0, n_q};
        else rem_q <= rem_sh;
        if (cnt_q == CntBits'(1)) begin
          rf_q[dst_q] <= (rem_sh >= {1'b0, n_q}) ? word_t'(rem_sh - {1'b0, n_q})
                                                 : rem_sh[ModBits-1:0];
        end
      end
      S_GDIV: begin
        if (r1_q != '0) begin
          if (q_bit) begin
            qrem_q <= q_shift_sub;
            q_q    <= q_q | (ModBits'(1) << sh_q);
          end
          if (sh_q != '0) begin
            sh_q <= sh_q - CntBits'(1);
          end else begin
            // q is final after this cycle; multiply q mod n by t1.
            opa_q <= t1g_q;
            opb_q <= (q_fin >= n_q) ? q_fin - n_q : q_fin;
            acc_q <= '0;
            cnt_q <= CntBits'(ModBits);
          end
        end else begin
          rf_q[R_LAM] <= t0g_q;
        end
      end
      S_GTMU: begin
        acc_q <= stepv;
        opb_q <= opb_q << 1;
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          r0_q   <= r1_q;
          r1_q   <= qrem_q;
          t0g_q  <= t1g_q;
          t1g_q  <= subm(t0g_q, stepv, n_q);
          qrem_q <= r1_q;
          q_q    <= '0;
          sh_q   <= CntBits'(ModBits - 1);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.done      = done_q;
  assign stat_o.ax_eq_bx  = (rf_q[R_AX] == rf_q[R_BX]);
  assign stat_o.ay_eq_by  = (rf_q[R_AY] == rf_q[R_BY]);
  assign stat_o.ysum_zero = (addm(rf_q[R_AY], rf_q[R_BY], n_q) == '0);
  assign stat_o.gcd_fail  = (r0_q != ModBits'(1));
  assign ax_o  = rf_q[R_AX];
  assign ay_o  = rf_q[R_AY];
  assign bx_o  = rf_q[R_BX];
  assign by_o  = rf_q[R_BY];
  assign t0_o  = rf_q[R_T0];
  assign t1_o  = rf_q[R_T1];
  assign gcd_o = r0_q;

endmodule

`default_nettype wire

[src/ecadd_ctrl.sv]
// ----------------------------------------------------------------------------
// ecadd_ctrl: sequencer for the point addition
// Steps through reduction, case selection, slope and sum with one datapath
// command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ecadd_ctrl
  import ecadd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     a_inf_i,
  input  wire logic     b_inf_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          busy_o,
  output logic          finish_o,
  output logic [1:0]    kind_o
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_RUN  = 3'b010,
    C_WAIT = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [4:0]  pc_q, pc_d;
  logic        ainf_q, binf_q;
  logic [1:0]  kind_q, kind_d;
  logic        fin_d, fin_q;
  dp_cmd_t     cmd;
  logic        last;
  logic        accept;

  assign accept = (state_q == C_IDLE) && start_i && !fin_q;

  // Micro-program. Step 5 is the branch point; doubling uses 6..9.
  always_comb begin
    cmd  = '{go: 1'b1, op: OP_NOP, src_a: R_ZER, src_b: R_ZER, dst: R_T0};
    last = 1'b0;
    case (pc_q)
      5'd0:  cmd.op = OP_LOAD;
      5'd1:  cmd = '{1'b1, OP_REDUCE, R_AX, R_ZER, R_AX};
      5'd2:  cmd = '{1'b1, OP_REDUCE, R_AY, R_ZER, R_AY};
      5'd3:  cmd = '{1'b1, OP_REDUCE, R_BX, R_ZER, R_BX};
      5'd4:  cmd = '{1'b1, OP_REDUCE, R_BY, R_ZER, R_BY};
      5'd5:  cmd = '{1'b1, OP_REDUCE, R_CF, R_ZER, R_CF};
      5'd6:  cmd = '{1'b1, OP_MUL, R_AX, R_AX, R_T0};
      5'd7:  cmd = '{1'b1, OP_MUL, R_T0, R_THR, R_T0};
      5'd8:  cmd = '{1'b1, OP_ADD, R_T0, R_CF, R_T1};
      5'd9:  cmd = '{1'b1, OP_ADD, R_AY, R_AY, R_T2};
      5'd10: cmd = '{1'b1, OP_NOP, R_ZER, R_ZER, R_T0};
      5'd11: cmd = '{1'b1, OP_SUB, R_BY, R_AY, R_T1};
      5'd12: cmd = '{1'b1, OP_SUB, R_BX, R_AX, R_T2};
      5'd13: cmd = '{1'b1, OP_GCD, R_T2, R_ZER, R_T0};
      5'd14: cmd = '{1'b1, OP_NOP, R_ZER, R_ZER, R_T0};
      5'd15: cmd = '{1'b1, OP_MUL, R_T1, R_LAM, R_LAM};
      5'd16: cmd = '{1'b1, OP_MUL, R_LAM, R_LAM, R_T0};
      5'd17: cmd = '{1'b1, OP_SUB, R_T0, R_BX, R_T0};
      5'd18: cmd = '{1'b1, OP_SUB, R_T0, R_AX, R_T0};
      5'd19: cmd = '{1'b1, OP_SUB, R_AX, R_T0, R_T2};
      5'd20: cmd = '{1'b1, OP_MUL, R_LAM, R_T2, R_T1};
      5'd21: begin
        cmd  = '{1'b1, OP_SUB, R_T1, R_AY, R_T1};
        last = 1'b1;
      end
      default: cmd.op = OP_NOP;
    endcase
  end

  // The load is issued at the accepting edge so the operands are taken then.
  assign cmd_o.go    = (state_q == C_RUN) || accept;
  assign cmd_o.op    = cmd.op;
  assign cmd_o.src_a = cmd.src_a;
  assign cmd_o.src_b = cmd.src_b;
  assign cmd_o.dst   = cmd.dst;

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    kind_d  = kind_q;
    fin_d   = 1'b0;
    case (state_q)
      C_IDLE: if (accept) begin
        state_d = C_WAIT;
        pc_d    = '0;
      end
      C_RUN:  state_d = C_WAIT;
      C_WAIT: if (stat_i.done) begin
        state_d = C_RUN;
        pc_d    = pc_q + 5'd1;
        if (pc_q == 5'd5) begin
          if (ainf_q && binf_q) begin
            kind_d = KindInf; fin_d = 1'b1; state_d = C_IDLE;
          end else if (ainf_q) begin
            kind_d = KindB; fin_d = 1'b1; state_d = C_IDLE;
          end else if (binf_q) begin
            kind_d = KindA; fin_d = 1'b1; state_d = C_IDLE;
          end else if (stat_i.ax_eq_bx && stat_i.ysum_zero) begin
            kind_d = KindInf; fin_d = 1'b1; state_d = C_IDLE;
          end else begin
            kind_d = KindSum;
            pc_d = (stat_i.ax_eq_bx && stat_i.ay_eq_by) ? 5'd6 : 5'd11;
          end
        end else if (pc_q == 5'd9) begin
          pc_d = 5'd13;
        end else if (pc_q == 5'd13) begin
          if (stat_i.gcd_fail) begin
            fin_d = 1'b1; state_d = C_IDLE;
          end
        end else if (last) begin
          fin_d = 1'b1; state_d = C_IDLE;
        end
        if (fin_d) pc_d = '0;
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      pc_q    <= '0;
      kind_q  <= KindInf;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      kind_q  <= kind_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ainf_q <= a_inf_i;
      binf_q <= b_inf_i;
    end
  end

  assign busy_o   = (state_q != C_IDLE) || fin_q;
  assign finish_o = fin_q;
  assign kind_o   = kind_q;

endmodule

`default_nettype wire

[src/ec_affine_point_add_mod_n.sv]
// ----------------------------------------------------------------------------
// ec_affine_point_add_mod_n: affine point addition modulo n
// An addition finishes early when an operand or the sum is at infinity.
// Every transaction reduces its five operands with bit-serial reductions; a
// chord sum then needs three and a doubling five bit-serial multiplications,
// and the extended gcd runs a quotient search and then a multiplication per
// Euclidean step, up to about 46 steps for a 32-bit modulus. busy is high
// from the accepted start until the result strobe; the result appears on the
// output ports for one cycle with done_o and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_affine_point_add_mod_n
  import ecadd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_idx_i,
  input  wire word_t cfg_data_i,
  input  wire logic  start,
  output logic       busy,
  input  wire word_t a_x_i,
  input  wire word_t a_y_i,
  input  wire logic  a_inf_i,
  input  wire word_t b_x_i,
  input  wire word_t b_y_i,
  input  wire logic  b_inf_i,
  output logic       done_o,
  output word_t      sum_x_o,
  output word_t      sum_y_o,
  output logic       sum_inf_o,
  output logic       no_inverse_o,
  output word_t      factor_o
);

  word_t modulus_q, coeff_q, n_eff;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  word_t ax, ay, bx, by, t0, t1, g;
  logic fin;
  logic [1:0] kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModBits'(3);
      coeff_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'b0) modulus_q <= cfg_data_i;
      else coeff_q <= cfg_data_i;
    end
  end

  assign n_eff = (modulus_q < ModBits'(3)) ? ModBits'(3) : modulus_q;

  ecadd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .a_inf_i, .b_inf_i,
    .stat_i(stat),
    .cmd_o(cmd), .busy_o(busy), .finish_o(fin), .kind_o(kind)
  );

  ecadd_datapath u_dp (
    .clk_i, .rst_ni,
    .n_i(n_eff), .coef_i(coeff_q),
    .a_x_i, .a_y_i, .b_x_i, .b_y_i,
    .cmd_i(cmd), .stat_o(stat),
    .ax_o(ax), .ay_o(ay), .bx_o(bx), .by_o(by),
    .t0_o(t0), .t1_o(t1), .gcd_o(g)
  );

  logic fail;
  assign fail = (kind == KindSum) && stat.gcd_fail;

  always_comb begin
    sum_x_o = '0; sum_y_o = '0; sum_inf_o = 1'b0;
    case (kind)
      KindInf: sum_inf_o = 1'b1;
      KindA: begin sum_x_o = ax; sum_y_o = ay; end
      KindB: begin sum_x_o = bx; sum_y_o = by; end
      default: if (!fail) begin sum_x_o = t0; sum_y_o = t1; end
    endcase
  end

  assign done_o       = fin;
  assign no_inverse_o = fail;
  assign factor_o     = fail ? g : ModBits'(1);

endmodule

`default_nettype wire

[src/ecadd_checker.sv]
// ----------------------------------------------------------------------------
// ecadd_checker: port-level checks for the point adder
// Watches the command handshake and the shape of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module ecadd_checker
  import ecadd_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  start,
  input wire logic  busy,
  input wire logic  done_o,
  input wire logic  sum_inf_o,
  input wire logic  no_inverse_o,
  input wire word_t sum_x_o,
  input wire word_t factor_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction not busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside a transaction");

  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_inverse_o) |-> (!sum_inf_o && sum_x_o == '0))
    else $error("failed result carries a point");

  a_factor_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !no_inverse_o) |-> (factor_o == ModBits'(1)))
    else $error("factor not one on success");

endmodule

bind ec_affine_point_add_mod_n ecadd_checker u_checker (.*);

`default_nettype wire

[test/ec_affine_point_add_mod_n_checker.sv]
// ----------------------------------------------------------------------------
// ec_affine_point_add_mod_n_checker: result checker for the affine point adder
// Watches the command, configuration and result ports, predicts each sum with
// a behavioural model of curve point addition modulo n, and compares it field
// by field with what the adder returns.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_affine_point_add_mod_n_checker
  import ecadd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_idx_i,
  input  wire word_t cfg_data_i,
  input  wire logic  start_i,
  input  wire logic  busy_i,
  input  wire word_t a_x_i,
  input  wire word_t a_y_i,
  input  wire logic  a_inf_i,
  input  wire word_t b_x_i,
  input  wire word_t b_y_i,
  input  wire logic  b_inf_i,
  input  wire logic  done_i,
  input  wire word_t sum_x_i,
  input  wire word_t sum_y_i,
  input  wire logic  sum_inf_i,
  input  wire logic  no_inverse_i,
  input  wire word_t factor_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam bit IdxModulus = 1'b0;
  localparam bit IdxCoeff   = 1'b1;

  typedef struct packed {
    word_t x;
    word_t y;
    logic  inf;
    logic  noinv;
    word_t fac;
  } point_sum_t;

  point_sum_t sums_due[$];
  word_t      mod_reg;
  word_t      coeff_reg;

  function automatic logic [63:0] mod_add(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] room;
    room = n - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    return (a >= b) ? a - b : a + (n - b);
  endfunction

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    return (a * b) % n;
  endfunction

  function automatic point_sum_t add_points(word_t axw, word_t ayw, logic ai,
                                            word_t bxw, word_t byw, logic bi);
    logic [63:0] n, ax, ay, bx, by, cf, num, den, r0, r1, r2, t0, t1, t2, q, lam;
    logic [63:0] sx;
    point_sum_t  s;
    n  = (mod_reg < 3) ? 64'd3 : {32'd0, mod_reg};
    ax = axw % n; ay = ayw % n; bx = bxw % n; by = byw % n;
    cf = coeff_reg % n;
    s  = '{x: '0, y: '0, inf: 1'b0, noinv: 1'b0, fac: 32'd1};
    if (ai) begin
      if (bi) s.inf = 1'b1;
      else begin
        s.x = word_t'(bx); s.y = word_t'(by);
      end
    end else if (bi) begin
      s.x = word_t'(ax); s.y = word_t'(ay);
    end else if (ax == bx && mod_add(ay, by, n) == 0) begin
      s.inf = 1'b1;
    end else begin
      if (ax == bx && ay == by) begin
        num = mod_add(mod_mul(64'd3, mod_mul(ax, ax, n), n), cf, n);
        den = mod_add(ay, ay, n);
      end else begin
        num = mod_sub(by, ay, n);
        den = mod_sub(bx, ax, n);
      end
      r0 = n; r1 = den; t0 = 64'd0; t1 = 64'd1;
      while (r1 != 0) begin
        q  = r0 / r1;
        r2 = r0 - q * r1;
        t2 = mod_sub(t0, mod_mul(q % n, t1, n), n);
        r0 = r1; r1 = r2; t0 = t1; t1 = t2;
      end
      if (r0 > 1) begin
        s.noinv = 1'b1;
        s.fac   = word_t'(r0);
      end else begin
        lam = mod_mul(num, t0, n);
        sx  = mod_sub(mod_sub(mod_mul(lam, lam, n), bx, n), ax, n);
        s.x = word_t'(sx);
        s.y = word_t'(mod_sub(mod_mul(lam, mod_sub(ax, sx, n), n), ay, n));
      end
    end
    return s;
  endfunction

  assign pending_o = sums_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    point_sum_t e;
    if (!rst_ni) begin
      mod_reg      <= 32'd3;
      coeff_reg    <= '0;
      fail_count_o <= 0;
      sums_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == IdxModulus) mod_reg <= cfg_data_i;
        else if (cfg_idx_i == IdxCoeff) coeff_reg <= cfg_data_i;
      end
      if (start_i && !busy_i)
        sums_due.push_back(add_points(a_x_i, a_y_i, a_inf_i, b_x_i, b_y_i, b_inf_i));
      if (done_i) begin
        if (sums_due.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h inf=%b noinv=%b factor=%h", $time,
                   sum_x_i, sum_y_i, sum_inf_i, no_inverse_i, factor_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = sums_due.pop_front();
          if (e != {sum_x_i, sum_y_i, sum_inf_i, no_inverse_i, factor_i}) begin
            $display("%0t: mismatch expected x=%h y=%h inf=%b noinv=%b factor=%h", $time,
                     e.x, e.y, e.inf, e.noinv, e.fac);
            $display("%0t:          actual   x=%h y=%h inf=%b noinv=%b factor=%h", $time,
                     sum_x_i, sum_y_i, sum_inf_i, no_inverse_i, factor_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[test/tb_ec_affine_point_add_mod_n.sv]
// ----------------------------------------------------------------------------
// tb_ec_affine_point_add_mod_n: regression for the affine point adder
// Drives directed and random point pairs under several moduli and curve
// coefficients with random gaps; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ec_affine_point_add_mod_n;
  import ecadd_pkg::*;

  localparam bit IdxModulus = 1'b0;
  localparam bit IdxCoeff   = 1'b1;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_we_i = 1'b0;
  logic  cfg_idx_i = IdxModulus;
  word_t cfg_data_i = '0;
  logic  start = 1'b0;
  logic  busy;
  word_t a_x_i = '0, a_y_i = '0, b_x_i = '0, b_y_i = '0;
  logic  a_inf_i = 1'b0, b_inf_i = 1'b0;
  logic  done_o, sum_inf_o, no_inverse_o;
  word_t sum_x_o, sum_y_o, factor_o;
  int    fail_count, pending;
  word_t cur_mod;

  ec_affine_point_add_mod_n dut (.*);

  ec_affine_point_add_mod_n_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .start_i(start), .busy_i(busy),
    .a_x_i, .a_y_i, .a_inf_i, .b_x_i, .b_y_i, .b_inf_i,
    .done_i(done_o), .sum_x_i(sum_x_o), .sum_y_i(sum_y_o), .sum_inf_i(sum_inf_o),
    .no_inverse_i(no_inverse_o), .factor_i(factor_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #40000000;
    $display("ec_affine_point_add_mod_n regression: fail");
    $finish;
  end

  task automatic write_reg(input bit idx, input word_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == IdxModulus) cur_mod = val;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    repeat ((r < 92) ? $urandom_range(1, 4) : $urandom_range(20, 300)) @(posedge clk_i);
  endtask

  task automatic add_pair(input word_t ax, input word_t ay, input logic ai,
                          input word_t bx, input word_t by, input logic bi);
    start   <= 1'b1;
    a_x_i   <= ax; a_y_i <= ay; a_inf_i <= ai;
    b_x_i   <= bx; b_y_i <= by; b_inf_i <= bi;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
    idle_gap();
  endtask

  function automatic word_t coord();
    word_t n;
    n = (cur_mod < 3) ? 32'd3 : cur_mod;
    case ($urandom_range(0, 9))
      0: return '1;
      1: return $urandom();
      2: return n - 1;
      3: return 0;
      default: return $urandom() % n;
    endcase
  endfunction

  task automatic random_pairs(input int count);
    word_t ax, ay, bx, by, n;
    int    k;
    n = (cur_mod < 3) ? 32'd3 : cur_mod;
    repeat (count) begin
      ax = coord(); ay = coord(); bx = coord(); by = coord();
      k = $urandom_range(0, 9);
      if (k == 0) begin
        bx = ax; by = ay;
      end else if (k == 1) begin
        bx = ax; by = (n - (ay % n)) % n;
      end else if (k == 2) bx = ax;
      add_pair(ax, ay, $urandom_range(0, 9) == 0, bx, by, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    word_t moduli[6];
    word_t coeffs[6];
    cur_mod = 32'd3;
    moduli = '{32'd0, 32'd455839, 32'hFFFFFFFF, 32'd3, 32'd1000003, 32'hFFFFFFFB};
    coeffs = '{32'd5, 32'hFFFFFFFF, 32'd0, 32'd2, 32'd123457, 32'h80000000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_pair(32'd1, 32'd1, 1'b0, 32'd1, 32'd1, 1'b0);
    wait_idle();
    write_reg(IdxModulus, 32'd455839);
    write_reg(IdxCoeff, 32'd5);
    add_pair(32'd10, 32'd20, 1'b1, 32'd30, 32'd40, 1'b1);
    add_pair(32'd10, 32'd20, 1'b1, 32'd30, 32'd40, 1'b0);
    add_pair(32'd10, 32'd20, 1'b0, 32'd30, 32'd40, 1'b1);
    add_pair(32'd10, 32'd20, 1'b0, 32'd10, 32'd455819, 1'b0);
    add_pair(32'd10, 32'd20, 1'b0, 32'd10, 32'd20, 1'b0);
    add_pair(32'd10, 32'd20, 1'b0, 32'd10, 32'd21, 1'b0);
    add_pair(32'd10, 32'd20, 1'b0, 32'd609, 32'd7, 1'b0);
    add_pair(32'd10, 32'd20, 1'b0, 32'd11, 32'd7, 1'b0);
    add_pair(32'd5, 32'd0, 1'b0, 32'd5, 32'd0, 1'b0);
    add_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
    add_pair(32'hFFFFFFFF, 32'd0, 1'b1, 32'h0, 32'hFFFFFFFF, 1'b0);
    add_pair(32'h0, 32'h0, 1'b0, 32'hFFFFFFFF, 32'h12345678, 1'b0);
    random_pairs(40);

    foreach (moduli[i]) begin
      wait_idle();
      write_reg(IdxModulus, moduli[i]);
      write_reg(IdxCoeff, coeffs[i]);
      random_pairs(165);
    end

    wait_idle();
    repeat (3000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("ec_affine_point_add_mod_n regression: pass");
    else
      $display("ec_affine_point_add_mod_n regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

[ec_affine_point_add_mod_n.f]
src/ecadd_pkg.sv
src/ecadd_datapath.sv
src/ecadd_ctrl.sv
src/ec_affine_point_add_mod_n.sv
src/ecadd_checker.sv
test/ec_affine_point_add_mod_n_checker.sv
test/tb_ec_affine_point_add_mod_n.sv
